// ===== rtl/core/mrws_pkg.sv =====
package mrws_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CONTEXT_MASK  = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_DISCONTINUOUS = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MASK_W      = 16;
    localparam int WIN_W       = 13;
    localparam int CHAR_W      = 8;
    localparam int NUM_W       = 48;
    localparam int DEN_W       = 34;

    // Contexts below this index are uppercase (methylated) calls.
    localparam int UPPER_LIMIT = 8;

    localparam logic [NUM_W-1:0] SUM_MAX = {NUM_W{1'b1}};

    // floor(x/3) = (x * RECIP3) >> RECIP3_SH, exact for x below 2^17.
    localparam int RECIP3_SH = 19;
    localparam logic [17:0] RECIP3 = 18'h2AAAB;

    // Steps of the shared multiplier.
    localparam logic [2:0] MS_NONE = 3'd0;
    localparam logic [2:0] MS_AB   = 3'd1;
    localparam logic [2:0] MS_ABC  = 3'd2;
    localparam logic [2:0] MS_TRI  = 3'd3;
    localparam logic [2:0] MS_EXT  = 3'd4;

    typedef struct packed {
        logic       take;
        logic       prep;
        logic [2:0] mstep;
        logic       fin;
        logic       acc_run;
        logic       emit_run;
        logic       emit_sum;
        logic       sel_sum;
    } cmd_t;

    typedef struct packed {
        logic close_pend;
        logic eor_pend;
        logic disc;
    } sts_t;

endpackage

// ===== rtl/core/mrws_ctrl.sv =====
module mrws_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  mrws_pkg::sts_t sts,
    output mrws_pkg::cmd_t cmd
);
    import mrws_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECIDE  = 4'd1;
    localparam logic [3:0] ST_PREP    = 4'd2;
    localparam logic [3:0] ST_M1      = 4'd3;
    localparam logic [3:0] ST_M2      = 4'd4;
    localparam logic [3:0] ST_M3      = 4'd5;
    localparam logic [3:0] ST_M4      = 4'd6;
    localparam logic [3:0] ST_FIN     = 4'd7;
    localparam logic [3:0] ST_RUN_OUT = 4'd8;
    localparam logic [3:0] ST_SUM_OUT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       sel_sum_reg, sel_sum_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        sel_sum_next = sel_sum_reg;
        cmd          = '0;
        cmd.sel_sum  = sel_sum_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.close_pend)
                begin
                    sel_sum_next = 1'b0;
                    state_next   = ST_PREP;
                end
                else if (sts.eor_pend)
                begin
                    sel_sum_next = 1'b1;
                    state_next   = ST_PREP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                cmd.mstep  = MS_AB;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.mstep  = MS_ABC;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                cmd.mstep  = MS_TRI;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                cmd.mstep  = MS_EXT;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = sel_sum_reg ? ST_SUM_OUT : ST_RUN_OUT;
            end
            ST_RUN_OUT:
            begin
                if (!sts.disc || out_free)
                begin
                    cmd.acc_run  = 1'b1;
                    cmd.emit_run = sts.disc;
                    if (sts.eor_pend)
                    begin
                        sel_sum_next = 1'b1;
                        state_next   = ST_PREP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUM_OUT:
            begin
                if (out_free)
                begin
                    cmd.emit_sum = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit_run || cmd.emit_sum)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_sum_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_sum_reg   <= sel_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/mrws_dpath.sv =====
module mrws_dpath #(
    parameter int MAX_COUNT = 4096,
    parameter int READ_LEN  = 8192,
    parameter int CW        = 12,
    parameter int OW        = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [mrws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mrws_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [mrws_pkg::CHAR_W-1:0]   call_char,
    input  logic                          end_of_read,
    input  mrws_pkg::cmd_t                cmd,
    output mrws_pkg::sts_t                sts,
    output logic                          kind,
    output logic [OW-1:0]                 run_start,
    output logic [OW-1:0]                 run_end,
    output logic [mrws_pkg::NUM_W-1:0]    numerator,
    output logic [mrws_pkg::DEN_W-1:0]    denominator,
    output logic [CW-1:0]                 context_bases,
    output logic                          last_of_item
);
    import mrws_pkg::*;

    localparam int KW = (CW + 1 > WIN_W) ? CW + 1 : WIN_W;
    localparam int SW = 3 * CW - 2;
    localparam int AW = 2 * CW + 2;
    localparam int BW = CW + 1;
    localparam int PW = AW + BW;
    localparam int QW = BW + RECIP3_SH + 1;
    localparam logic [KW-1:0] K_DEFAULT = KW'(MAX_COUNT);
    localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_COUNT - 1);
    localparam logic [OW-1:0] OFF_MAX   = OW'(READ_LEN - 1);

    // Configuration.
    logic [MASK_W-1:0] mask_reg;
    logic [WIN_W-1:0]  win_reg;
    logic              disc_reg;

    // Live read state.
    logic [OW-1:0]    off_reg, off_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    rlen_reg, rlen_next;
    logic [OW-1:0]    first_reg, first_next;
    logic [OW-1:0]    last_reg, last_next;
    logic [NUM_W-1:0] sum_reg;

    // Snapshot of the accepted transaction.
    logic          close_pend_reg, eor_pend_reg;
    logic [CW-1:0] clen_reg, scnt_reg;
    logic [OW-1:0] cfirst_reg, clast_reg, soff_reg;

    // Score unit.
    logic [CW-1:0] m_reg, d_reg;
    logic [BW-1:0] x3_reg;
    logic [1:0]    rem_reg;
    logic [PW-1:0] prod_reg;
    logic [SW-1:0] pyr_reg, score_reg;

    logic [CHAR_W:0]  char_p2;
    logic [3:0]       ctx;
    logic             enabled, upper, closing;
    logic [CW-1:0]    cnt_inc, rlen_ext;
    logic [CW-1:0]    n_sel, m_val;
    logic [KW-1:0]    k_val;
    logic [BW-1:0]    x_val, x3_val, rem_full;
    logic [QW-1:0]    q_full;
    logic [BW-1:0]    op_a, op_b, op_c;
    logic [AW-1:0]    mul_a;
    logic [BW-1:0]    mul_b;
    logic [PW-1:0]    mul_p;
    logic [NUM_W:0]   sum_wide;
    logic [NUM_W-1:0] sum_sat;

    assign sts.close_pend = close_pend_reg;
    assign sts.eor_pend   = eor_pend_reg;
    assign sts.disc       = disc_reg;

    // Context index and run tracking for the incoming character.
    always_comb
    begin
        char_p2  = {1'b0, call_char} + (CHAR_W + 1)'(2);
        ctx      = char_p2[5:2];
        enabled  = mask_reg[ctx];
        upper    = (32'(ctx) < UPPER_LIMIT);
        cnt_inc  = (enabled && cnt_reg != CNT_MAX) ? cnt_reg + CW'(1) : cnt_reg;
        rlen_ext = rlen_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (enabled && upper)
        begin
            if (rlen_reg == '0)
                first_next = off_reg;
            last_next = off_reg;
            if (rlen_reg != CNT_MAX)
                rlen_ext = rlen_reg + CW'(1);
        end
        closing = ((enabled && !upper) || end_of_read) && (rlen_ext != '0);
        if (end_of_read)
        begin
            off_next   = '0;
            cnt_next   = '0;
            rlen_next  = '0;
        end
        else
        begin
            off_next  = (off_reg != OFF_MAX) ? off_reg + OW'(1) : off_reg;
            cnt_next  = cnt_inc;
            rlen_next = closing ? '0 : rlen_ext;
        end
    end

    // Score preparation: m = min(n,k), d = n - m, and the factor of
    // m(m+1)(m+2) that is divisible by three, found from (m+2) mod 3.
    always_comb
    begin
        n_sel    = cmd.sel_sum ? scnt_reg : clen_reg;
        k_val    = (win_reg == '0) ? K_DEFAULT : KW'(win_reg);
        m_val    = (KW'(n_sel) > k_val) ? k_val[CW-1:0] : n_sel;
        x_val    = BW'(m_val) + BW'(2);
        q_full   = QW'(x_val) * QW'(RECIP3);
        x3_val   = q_full[RECIP3_SH +: BW];
        rem_full = x_val - ((x3_val << 1) + x3_val);
    end

    always_comb
    begin
        op_a = BW'(m_reg);
        op_b = BW'(m_reg) + BW'(1);
        op_c = BW'(m_reg) + BW'(2);
        case (rem_reg)
            2'd0:    op_c = x3_reg;
            2'd1:    op_b = x3_reg;
            2'd2:    op_a = x3_reg;
            default: op_a = x3_reg;
        endcase
    end

    // One shared multiplier, stepped by the controller.
    always_comb
    begin
        case (cmd.mstep)
            MS_AB:
            begin
                mul_a = AW'(op_a);
                mul_b = op_b;
            end
            MS_ABC:
            begin
                mul_a = prod_reg[AW-1:0];
                mul_b = op_c;
            end
            MS_TRI:
            begin
                mul_a = AW'(m_reg);
                mul_b = BW'(m_reg) + BW'(1);
            end
            MS_EXT:
            begin
                mul_a = AW'(prod_reg[2*CW:1]);
                mul_b = BW'(d_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + (NUM_W + 1)'(score_reg);
        sum_sat  = sum_wide[NUM_W] ? SUM_MAX : sum_wide[NUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= MASK_W'(32896);
            win_reg        <= '0;
            disc_reg       <= 1'b0;
            off_reg        <= '0;
            cnt_reg        <= '0;
            rlen_reg       <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            sum_reg        <= '0;
            close_pend_reg <= 1'b0;
            eor_pend_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CONTEXT_MASK:  mask_reg <= cfg_data[MASK_W-1:0];
                    CFG_WINDOW_LIMIT:  win_reg  <= cfg_data[WIN_W-1:0];
                    CFG_DISCONTINUOUS: disc_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            if (cmd.take)
            begin
                off_reg        <= off_next;
                cnt_reg        <= cnt_next;
                rlen_reg       <= rlen_next;
                first_reg      <= end_of_read ? '0 : first_next;
                last_reg       <= end_of_read ? '0 : last_next;
                close_pend_reg <= closing;
                eor_pend_reg   <= end_of_read;
            end
            if (cmd.acc_run)
                sum_reg <= sum_sat;
            else if (cmd.emit_sum)
                sum_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            clen_reg   <= rlen_ext;
            cfirst_reg <= first_next;
            clast_reg  <= last_next;
            soff_reg   <= off_reg;
            scnt_reg   <= cnt_inc;
        end
        if (cmd.prep)
        begin
            m_reg   <= m_val;
            d_reg   <= n_sel - m_val;
            x3_reg  <= x3_val;
            rem_reg <= rem_full[1:0];
        end
        if (cmd.mstep == MS_AB || cmd.mstep == MS_TRI || cmd.mstep == MS_EXT)
            prod_reg <= mul_p;
        if (cmd.mstep == MS_ABC)
            pyr_reg <= mul_p[SW:1];
        if (cmd.fin)
            score_reg <= pyr_reg + prod_reg[SW-1:0];
        if (cmd.emit_run)
        begin
            kind          <= 1'b0;
            run_start     <= cfirst_reg;
            run_end       <= clast_reg;
            numerator     <= NUM_W'(score_reg);
            denominator   <= '0;
            context_bases <= clen_reg;
            last_of_item  <= !eor_pend_reg;
        end
        else if (cmd.emit_sum)
        begin
            kind          <= 1'b1;
            run_start     <= '0;
            run_end       <= soff_reg;
            numerator     <= sum_reg;
            denominator   <= DEN_W'(score_reg);
            context_bases <= scnt_reg;
            last_of_item  <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/methylation_run_wtf_scorer.sv =====
// Methylation run scorer. Each input transaction carries one call character
// and an end-of-read flag; closed methylated runs (discontinuous mode only)
// and one summary per read come out on the result channel, a run result
// always ahead of the summary of the same read. Each score comes from the single
// shared multiplier that steps through the score polynomial, four products
// per score. A character that closes no run and ends no read needs no score;
// after one that closes a run, ends a read or both, the next character is not
// taken until its scores are done and any stall of the result channel has
// passed. A finished result waits in the output register while the next
// character is taken.
module methylation_run_wtf_scorer #(
    parameter int MAX_COUNT = 4096,
    parameter int READ_LEN  = 8192
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mrws_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mrws_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mrws_pkg::CHAR_W-1:0]          call_char,
    input  logic                                 end_of_read,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 kind,
    output logic [$clog2(READ_LEN)-1:0]          run_start,
    output logic [$clog2(READ_LEN)-1:0]          run_end,
    output logic [mrws_pkg::NUM_W-1:0]           numerator,
    output logic [mrws_pkg::DEN_W-1:0]           denominator,
    output logic [$clog2(MAX_COUNT)-1:0]         context_bases,
    output logic                                 last_of_item
);
    import mrws_pkg::*;

    localparam int CW = $clog2(MAX_COUNT);
    localparam int OW = $clog2(READ_LEN);

    cmd_t cmd;
    sts_t sts;

    mrws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mrws_dpath #(
        .MAX_COUNT (MAX_COUNT),
        .READ_LEN  (READ_LEN),
        .CW        (CW),
        .OW        (OW)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .call_char     (call_char),
        .end_of_read   (end_of_read),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .run_start     (run_start),
        .run_end       (run_end),
        .numerator     (numerator),
        .denominator   (denominator),
        .context_bases (context_bases),
        .last_of_item  (last_of_item)
    );

endmodule

// ===== dv/mrws_run_score_check.sv =====
`timescale 1ns / 100ps

module mrws_run_score_check
    import mrws_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [CHAR_W-1:0]      call_char,
    input  logic                   end_of_read,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   kind,
    input  logic [12:0]            run_start,
    input  logic [12:0]            run_end,
    input  logic [NUM_W-1:0]       numerator,
    input  logic [DEN_W-1:0]       denominator,
    input  logic [11:0]            context_bases,
    input  logic                   last_of_item,
    output int                     failures,
    output int                     open_count
);

    localparam int MAX_COUNT = 4096;
    localparam int READ_LEN  = 8192;
    localparam logic [MASK_W-1:0] MASK_RESET = 16'h8080;
    localparam longint unsigned SUM_CAP = SUM_MAX;

    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [12:0]      start_pos;
        logic [12:0]      end_pos;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [11:0]      bases;
        logic             closing;
    } run_report_t;

    // Shadow of the configuration registers.
    logic [MASK_W-1:0] mask_q;
    logic [WIN_W-1:0]  win_q;
    logic              disc_q;

    // Per-read state.
    int                read_pos;
    int                base_count;
    int                run_len;
    int                run_lo;
    int                run_hi;
    longint unsigned   score_total;

    run_report_t       pending_reports[$];
    run_report_t       fresh_reports[$];

    function automatic longint unsigned window_score(input longint unsigned n);
        longint unsigned k;
        k = (win_q == 0) ? MAX_COUNT : win_q;
        if (n <= k)
            return n * (n + 1) * (n + 2) / 6;
        return k * (k + 1) * (k + 2) / 6 + (n - k) * (k * (k + 1) / 2);
    endfunction

    function automatic void field_check(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic close_run();
        longint unsigned s;
        run_report_t rec;
        s = window_score(run_len);
        score_total = (s > SUM_CAP - score_total) ? SUM_CAP : score_total + s;
        if (disc_q)
        begin
            rec.kind      = KIND_RUN;
            rec.start_pos = 13'(run_lo);
            rec.end_pos   = 13'(run_hi);
            rec.num       = NUM_W'(s);
            rec.den       = '0;
            rec.bases     = 12'(run_len);
            rec.closing   = 1'b0;
            fresh_reports = {fresh_reports, rec};
        end
        run_len = 0;
    endtask

    task automatic take_char(input logic [CHAR_W-1:0] c, input logic eor);
        int idx;
        run_report_t rec;
        fresh_reports.delete();
        idx = ((int'(c) + 2) >> 2) & 15;
        if (mask_q[idx])
        begin
            if (base_count < MAX_COUNT - 1)
                base_count++;
            if (idx < UPPER_LIMIT)
            begin
                if (run_len == 0)
                    run_lo = read_pos;
                run_hi = read_pos;
                if (run_len < MAX_COUNT - 1)
                    run_len++;
            end
            else if (run_len != 0)
            begin
                close_run();
            end
        end

        if (eor)
        begin
            if (run_len != 0)
                close_run();
            rec.kind      = KIND_SUMMARY;
            rec.start_pos = '0;
            rec.end_pos   = 13'(read_pos);
            rec.num       = NUM_W'(score_total);
            rec.den       = DEN_W'(window_score(base_count));
            rec.bases     = 12'(base_count);
            rec.closing   = 1'b0;
            fresh_reports = {fresh_reports, rec};
            read_pos    = 0;
            base_count  = 0;
            run_len     = 0;
            run_lo      = 0;
            run_hi      = 0;
            score_total = 0;
        end
        else if (read_pos < READ_LEN - 1)
        begin
            read_pos++;
        end

        if (fresh_reports.size() > 0)
            fresh_reports[fresh_reports.size() - 1].closing = 1'b1;
        pending_reports = {pending_reports, fresh_reports};
    endtask

    task automatic check_report();
        run_report_t want;
        if (pending_reports.size() == 0)
        begin
            $error("result transaction arrived with no expectation waiting");
            failures++;
        end
        else
        begin
            want = pending_reports.pop_front();
            field_check("kind", want.kind, kind);
            field_check("run_start", want.start_pos, run_start);
            field_check("run_end", want.end_pos, run_end);
            field_check("numerator", want.num, numerator);
            field_check("denominator", want.den, denominator);
            field_check("context_bases", want.bases, context_bases);
            field_check("last_of_item", want.closing, last_of_item);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_q      = MASK_RESET;
            win_q       = '0;
            disc_q      = 1'b0;
            read_pos    = 0;
            base_count  = 0;
            run_len     = 0;
            run_lo      = 0;
            run_hi      = 0;
            score_total = 0;
            failures    = 0;
            pending_reports.delete();
            open_count  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CONTEXT_MASK:  mask_q = cfg_data[MASK_W-1:0];
                    CFG_WINDOW_LIMIT:  win_q  = cfg_data[WIN_W-1:0];
                    CFG_DISCONTINUOUS: disc_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_char(call_char, end_of_read);
            if (out_valid && out_ready)
                check_report();
            open_count = pending_reports.size();
        end
    end

endmodule

// ===== dv/methylation_run_wtf_scorer_test.sv =====
`timescale 1ns / 100ps

module methylation_run_wtf_scorer_test;

    import mrws_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [CHAR_W-1:0]      call_char;
    logic                   end_of_read;
    logic                   out_valid;
    logic                   out_ready;
    logic                   kind;
    logic [12:0]            run_start;
    logic [12:0]            run_end;
    logic [NUM_W-1:0]       numerator;
    logic [DEN_W-1:0]       denominator;
    logic [11:0]            context_bases;
    logic                   last_of_item;

    int                     chk_errors;
    int                     chk_open;
    bit                     gaps_on;
    bit                     stalls_on;
    int                     stall_left = 0;
    logic [MASK_W-1:0]      cur_mask;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    methylation_run_wtf_scorer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .call_char     (call_char),
        .end_of_read   (end_of_read),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .run_start     (run_start),
        .run_end       (run_end),
        .numerator     (numerator),
        .denominator   (denominator),
        .context_bases (context_bases),
        .last_of_item  (last_of_item)
    );

    mrws_run_score_check score_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .call_char     (call_char),
        .end_of_read   (end_of_read),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .run_start     (run_start),
        .run_end       (run_end),
        .numerator     (numerator),
        .denominator   (denominator),
        .context_bases (context_bases),
        .last_of_item  (last_of_item),
        .failures      (chk_errors),
        .open_count    (chk_open)
    );

    // The result side stalls in bursts while stalls are enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_char(input logic [CHAR_W-1:0] c, input logic eor);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        call_char   <= c;
        end_of_read <= eor;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [MASK_W-1:0] mask, input logic [WIN_W-1:0] win,
                            input logic disc);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CONTEXT_MASK;
        cfg_data  <= mask;
        @(negedge clk);
        cfg_index <= CFG_WINDOW_LIMIT;
        cfg_data  <= CFG_DATA_W'(win);
        @(negedge clk);
        cfg_index <= CFG_DISCONTINUOUS;
        cfg_data  <= CFG_DATA_W'(disc);
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_mask = mask;
    endtask

    task automatic drain();
        int guard;
        for (guard = 0; guard < 50000 && chk_open != 0; guard++)
            @(negedge clk);
    endtask

    // A character that yields no result may still be in flight, so give the
    // block its worst-case latency before touching the registers.
    task automatic settle();
        in_valid <= 1'b0;
        drain();
        repeat (24) @(negedge clk);
    endtask

    // Any byte with the requested context index, spread over all four aliases.
    function automatic logic [CHAR_W-1:0] context_char(input int idx);
        return CHAR_W'(4 * idx + 64 * $urandom_range(0, 3) + $urandom_range(0, 3) - 2);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(input bit upper);
        int idx;
        int tries;
        idx = upper ? $urandom_range(0, UPPER_LIMIT - 1) : $urandom_range(UPPER_LIMIT, 15);
        for (tries = 0; tries < 4 && !cur_mask[idx]; tries++)
            idx = upper ? $urandom_range(0, UPPER_LIMIT - 1) : $urandom_range(UPPER_LIMIT, 15);
        return context_char(idx);
    endfunction

    task automatic run_reads(input int n);
        int done;
        int len;
        int i;
        bit upper;
        logic [CHAR_W-1:0] c;
        logic eor;
        done = 0;
        while (done < n)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 300) : $urandom_range(1, 30);
            upper = $urandom_range(0, 1);
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) < 3)
                    upper = !upper;
                c = ($urandom_range(0, 9) == 0) ? CHAR_W'($urandom) : pick_char(upper);
                // Occasionally cut the read short.
                eor = (i == len - 1) || ($urandom_range(0, 39) == 0);
                push_char(c, eor);
                done++;
            end
        end
    endtask

    initial
    begin
        logic [MASK_W-1:0] mask;
        logic [WIN_W-1:0]  win;
        logic              disc;

        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        call_char   = '0;
        end_of_read = 1'b0;
        out_ready   = 1'b0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        cur_mask    = 16'h8080;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: runs are scored but only the summary comes out,
        // including a run still open at the end of the read.
        push_char("Z", 1'b0);
        push_char("Z", 1'b0);
        push_char("z", 1'b0);
        push_char("Z", 1'b0);
        push_char("a", 1'b1);
        push_char(8'h00, 1'b1);
        settle();

        // Everything enabled, tiny window, per-run results.
        set_regs(16'hFFFF, 13'd2, 1'b1);
        push_char("Z", 1'b0);
        push_char("H", 1'b0);
        push_char("X", 1'b0);
        push_char("U", 1'b0);
        push_char("z", 1'b0);
        push_char("x", 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h80, 1'b0);
        push_char(8'h7F, 1'b1);
        push_char("Z", 1'b0);
        push_char("z", 1'b1);
        settle();

        // Nothing enabled, widest window.
        set_regs(16'h0000, 13'd8191, 1'b1);
        push_char("Z", 1'b0);
        push_char("z", 1'b1);
        settle();

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: mask = 16'hFFFF;
                1: mask = 16'h0000;
                2: mask = 16'h8080;
                3: mask = 16'h00FF;
                default: mask = MASK_W'($urandom_range(0, 16'hFFFF))
                                | MASK_W'(1 << $urandom_range(0, 7))
                                | MASK_W'(1 << $urandom_range(8, 15));
            endcase
            case (p)
                0: win = 13'd0;
                1: win = 13'd1;
                2: win = 13'd8191;
                3: win = 13'd4096;
                4: win = 13'd4095;
                default: win = ($urandom_range(0, 3) == 0) ? WIN_W'($urandom_range(0, 8191))
                                                            : WIN_W'($urandom_range(1, 12));
            endcase
            disc = (p % 3 != 1);
            gaps_on   = (p != 4 && p != 9);
            stalls_on = (p != 4 && p != 9);
            set_regs(mask, win, disc);
            run_reads(175);
            settle();
        end

        drain();
        repeat (40) @(negedge clk);
        if (chk_open != 0)
            $error("%0d expected results never arrived", chk_open);
        if (chk_errors == 0 && chk_open == 0)
            $display("methylation_run_wtf_scorer_test: done, clean");
        else
            $display("methylation_run_wtf_scorer_test: done, errors");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("methylation_run_wtf_scorer_test: done, errors");
        $finish;
    end

endmodule
